// ===== rtl/chtt_pkg.sv =====
// shared constants, codes and control types of the connection handle translation table
package chtt_pkg;

  localparam int ENTRIES  = 32;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HANDLE_W = 12;

  // virtual handle counter wraps through this mask
  localparam logic [HANDLE_W-1:0] WRAP_MASK = 12'h0EFF;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic [2:0] {
    FUNC_CONNECT    = 3'd0,
    FUNC_DISCONNECT = 3'd1,
    FUNC_PHYS2VIRT  = 3'd2,
    FUNC_VIRT2PHYS  = 3'd3,
    FUNC_RESET      = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_FREE = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the incoming request
    logic look;      // first search step, applies all ops but the removal
    logic free;      // second step of a disconnect, removes the entry
    logic capture;   // park the finished result while the output is busy
    logic out_load;  // write the output register
    logic out_held;  // output comes from the parked result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_disc;   // latched request is a disconnect
  } status_t;

endpackage

// ===== rtl/chtt_ctrl.sv =====
// sequencing state machine and output valid of the translation table
module chtt_ctrl import chtt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (status.is_disc) begin
          state_next = S_FREE;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_HOLD;
        end
      end
      S_FREE: begin
        cmd.free = 1'b1;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_held = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/chtt_dpath.sv =====
// entry table, match logic, handle counter and result registers
module chtt_dpath import chtt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output status_t status,
  input  logic [2:0]          func,
  input  logic [HANDLE_W-1:0] handle_in,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                found
);

  // lowest set bit of a slot vector
  function automatic logic [IDX_W:0] first_set(input logic [ENTRIES-1:0] vec);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

  logic [ENTRIES-1:0] entry_valid;
  handle_t            entry_virtual  [ENTRIES];
  handle_t            entry_physical [ENTRIES];
  handle_t            next_virtual;

  logic [2:0] req_func;
  handle_t    req_handle;
  handle_t    dis_virtual;
  logic       dis_hit;
  handle_t    res_handle;
  logic       res_found;

  logic               by_phys;
  handle_t            key;
  logic [ENTRIES-1:0] search_vec;
  logic [IDX_W:0]     enc;
  logic               hit;
  idx_t               idx;
  handle_t            cur_handle;
  logic               cur_found;
  logic               free_hit;

  assign status.is_disc = (req_func == FUNC_DISCONNECT);

  // the second disconnect step searches by the virtual handle just read
  assign by_phys = cmd.look && (req_func != FUNC_VIRT2PHYS);
  assign key     = cmd.free ? dis_virtual : req_handle;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.look && req_func == FUNC_CONNECT) begin
        search_vec[i] = !entry_valid[i];
      end else begin
        search_vec[i] = entry_valid[i] &&
          ((by_phys ? entry_physical[i] : entry_virtual[i]) == key);
      end
    end
  end

  assign enc = first_set(search_vec);
  assign hit = enc[IDX_W];
  assign idx = enc[IDX_W-1:0];

  // a disconnect whose physical search missed leaves nothing to free
  assign free_hit = dis_hit && hit;

  always_comb begin
    cur_handle = '0;
    cur_found  = 1'b0;
    if (cmd.free) begin
      cur_found  = free_hit;
      cur_handle = free_hit ? dis_virtual : '0;
    end else begin
      unique case (req_func)
        FUNC_CONNECT: begin
          cur_found  = hit;
          cur_handle = hit ? next_virtual : '0;
        end
        FUNC_PHYS2VIRT: begin
          cur_found  = hit;
          cur_handle = hit ? entry_virtual[idx] : '0;
        end
        FUNC_VIRT2PHYS: begin
          cur_found  = hit;
          cur_handle = hit ? entry_physical[idx] : '0;
        end
        FUNC_RESET: begin
          cur_found = 1'b1;
        end
        default: begin
          cur_found = 1'b0;
        end
      endcase
    end
  end

  // control state: valid bits and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      next_virtual <= '0;
    end else if (cmd.look) begin
      if (req_func == FUNC_CONNECT) begin
        next_virtual <= (next_virtual + 1'b1) & WRAP_MASK;
        if (hit) begin
          entry_valid[idx] <= 1'b1;
        end
      end else if (req_func == FUNC_RESET) begin
        entry_valid  <= '0;
        next_virtual <= '0;
      end
    end else if (cmd.free && free_hit) begin
      entry_valid[idx] <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func   <= func;
      req_handle <= handle_in;
    end
    if (cmd.look && req_func == FUNC_CONNECT && hit) begin
      entry_virtual[idx]  <= next_virtual;
      entry_physical[idx] <= req_handle;
    end
    if (cmd.look && req_func == FUNC_DISCONNECT) begin
      dis_virtual <= hit ? entry_virtual[idx] : '0;
      dis_hit     <= hit;
    end
    if (cmd.capture) begin
      res_handle <= cur_handle;
      res_found  <= cur_found;
    end
    if (cmd.out_load) begin
      handle_out <= cmd.out_held ? res_handle : cur_handle;
      found      <= cmd.out_held ? res_found  : cur_found;
    end
  end

endmodule

// ===== rtl/connection_handle_translation_table.sv =====
// top level: an accepted item is latched, searched in the look step and its result is
// written to the output register; a disconnect searches the table twice (look, then free),
// using the single shared compare and priority encoder. no new item is taken before the
// last is done, and a result that meets a stalled output is parked until it moves.
// synchronous reset clears all valid bits, the handle counter and the handshakes;
// handle contents are never read from a slot that is not valid.
module connection_handle_translation_table import chtt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          func,
  input  logic [HANDLE_W-1:0] handle_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                found
);

  // command and status between sequencer and table
  cmd_t    cmd;
  status_t status;

  // sequencer: one search step per cycle while no result is parked, output register handshake
  chtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // table storage, search and result registers
  chtt_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (func),
    .handle_in  (handle_in),
    .handle_out (handle_out),
    .found      (found)
  );

endmodule
